// ===== rtl/core/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Types, codes and sizes shared by the direct line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;

  // y position in fixed point, slope one bit wider so a steep slope still fits
  localparam int Y_BITS     = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_BITS = Y_BITS + 1;
  // |dy| and dx never exceed COORD_MAX - COORD_MIN, which fits COORD_BITS unsigned
  localparam int MAG_BITS   = COORD_BITS;
  localparam int NUM_BITS   = MAG_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [SLOPE_BITS-1:0] SLOPE_ONE = SLOPE_BITS'(1) << FRAC_BITS;

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 2;

  // configuration register index
  localparam int REG_MIRROR_MODE = 0;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PULL  = 1'b1;

  // mirror codes; any code with bit 1 set negates x
  localparam logic [1:0] MIRROR_NONE   = 2'd0;
  localparam logic [1:0] MIRROR_X_AXIS = 2'd1;
  localparam logic [1:0] MIRROR_Y_AXIS = 2'd2;

  typedef enum logic [1:0] {
    KIND_VERT = 2'd0,
    KIND_HORZ = 2'd1,
    KIND_GEN  = 2'd2
  } line_kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [Y_BITS-1:0]     y;
    logic                         last;
  } point_t;

  // negate, saturating the most negative code to the largest positive one
  function automatic logic signed [COORD_BITS-1:0] neg_sat(
    input logic signed [COORD_BITS-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v == COORD_MIN) begin
      r = COORD_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/direct_line_rasterizer_mirror_unit.sv =====
// ----------------------------------------------------------------------------
// direct_line_rasterizer_mirror_unit
// Slope-intercept line rasterizer with endpoint mirroring.
// ----------------------------------------------------------------------------
// A start transaction (req_type 0) loads a segment, mirrored per mirror_mode,
// and yields no point; each pull transaction (req_type 1) yields the next
// point, one per cycle while the skid register has room, with last_point set
// on the final one. A pull with no active segment yields nothing. After a
// start no transaction is taken until setup ends: S_SETUP alone for a
// vertical or horizontal run, and S_SETUP then S_DIV for a general line, whose
// slope comes from a bit-serial restoring divider producing one quotient bit per
// cycle. Points go through an output register backed by a one-entry skid
// register; a pull waits while the skid register is full.
// mirror_mode is the only APB register; every address reads and writes it.
module direct_line_rasterizer_mirror_unit
  import dlr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] seg_x0,
  input  logic signed [COORD_BITS-1:0] seg_y0,
  input  logic signed [COORD_BITS-1:0] seg_x1,
  input  logic signed [COORD_BITS-1:0] seg_y1,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [Y_BITS-1:0]     point_y_q8,
  output logic                         last_point,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV
  } state_t;

  state_t state;

  logic [1:0] mirror_mode;

  // segment state
  logic                         active;
  line_kind_t                   line_kind;
  logic signed [COORD_BITS-1:0] cursor_x;
  logic signed [COORD_BITS-1:0] limit_coord;
  logic signed [Y_BITS-1:0]     cursor_y;
  logic signed [SLOPE_BITS-1:0] slope_q8;

  // mirrored endpoints waiting for setup
  logic signed [COORD_BITS-1:0] ex0, ey0, ex1, ey1;

  // divider
  logic [MAG_BITS-1:0] rem;
  logic [MAG_BITS-1:0] den;
  logic [NUM_BITS-1:0] quo;
  logic [CNT_BITS-1:0] count;
  logic                dy_neg;

  // output register and skid
  point_t out_pt;
  point_t skid_pt;
  logic   skid_valid;

  // ---------------------------------------------------------------------------
  // configuration port: a single register, so every write lands on it
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(DATA_BITS-2){1'b0}}, mirror_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode <= MIRROR_NONE;
    end else if (cfg_wr) begin
      mirror_mode <= pwdata[1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  logic in_fire, start_fire, pull_fire, push, pop, is_last;
  point_t cur_pt;

  assign in_ready   = (state == S_IDLE) && !skid_valid;
  assign in_fire    = in_valid && in_ready;
  assign start_fire = in_fire && (req_type == REQ_START);
  assign pull_fire  = in_fire && (req_type == REQ_PULL);
  assign push       = pull_fire && active;
  assign pop        = out_valid && out_ready;

  assign is_last = (line_kind == KIND_VERT) ?
                   (cursor_y == {limit_coord, {FRAC_BITS{1'b0}}}) :
                   (cursor_x == limit_coord);

  assign cur_pt.x    = cursor_x;
  assign cur_pt.y    = cursor_y;
  assign cur_pt.last = is_last;

  assign point_x    = out_pt.x;
  assign point_y_q8 = out_pt.y;
  assign last_point = out_pt.last;

  // ---------------------------------------------------------------------------
  // mirroring at accept time
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] mx0, my0, mx1, my1;
  logic neg_x, neg_y;

  assign neg_x = mirror_mode[1];
  assign neg_y = (mirror_mode == MIRROR_X_AXIS);
  assign mx0 = neg_x ? neg_sat(seg_x0) : seg_x0;
  assign mx1 = neg_x ? neg_sat(seg_x1) : seg_x1;
  assign my0 = neg_y ? neg_sat(seg_y0) : seg_y0;
  assign my1 = neg_y ? neg_sat(seg_y1) : seg_y1;

  // ---------------------------------------------------------------------------
  // setup: classify, order left to right, prepare the divider
  // ---------------------------------------------------------------------------
  logic                         vertical, swap, horizontal;
  logic signed [COORD_BITS-1:0] lx0, lx1, ly0, ly1, ymin, ymax;
  logic signed [COORD_BITS:0]   dy, dx, dy_abs;

  assign vertical   = (ex0 == ex1);
  assign swap       = (ex1 < ex0);
  assign lx0        = swap ? ex1 : ex0;
  assign lx1        = swap ? ex0 : ex1;
  assign ly0        = swap ? ey1 : ey0;
  assign ly1        = swap ? ey0 : ey1;
  assign horizontal = (ly0 == ly1);
  assign ymin       = (ey0 < ey1) ? ey0 : ey1;
  assign ymax       = (ey0 < ey1) ? ey1 : ey0;
  assign dy         = {ly1[COORD_BITS-1], ly1} - {ly0[COORD_BITS-1], ly0};
  assign dx         = {lx1[COORD_BITS-1], lx1} - {lx0[COORD_BITS-1], lx0};
  assign dy_abs     = dy[COORD_BITS] ? -dy : dy;

  // ---------------------------------------------------------------------------
  // divider step: one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [MAG_BITS+1:0] trial;
  logic                take;
  logic [NUM_BITS:0]   quo_ext;

  assign trial   = {1'b0, rem, quo[NUM_BITS-1]} - {2'b00, den};
  assign take    = !trial[MAG_BITS+1];
  assign quo_ext = {1'b0, quo[NUM_BITS-2:0], take};

  // y step, truncated back to the point width; the true value stays in range
  logic signed [SLOPE_BITS-1:0] y_sum;
  assign y_sum = {cursor_y[Y_BITS-1], cursor_y} + slope_q8;

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
      count      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_fire) begin
            state  <= S_SETUP;
            active <= 1'b0;
          end else if (push && is_last) begin
            active <= 1'b0;
          end
        end
        S_SETUP: begin
          count <= CNT_BITS'(NUM_BITS - 1);
          if (vertical || horizontal) begin
            state  <= S_IDLE;
            active <= 1'b1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          count <= count - CNT_BITS'(1);
          if (count == '0) begin
            state  <= S_IDLE;
            active <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (!out_valid || pop) begin
        out_valid  <= skid_valid || push;
        skid_valid <= skid_valid && push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (start_fire) begin
      ex0 <= mx0;
      ey0 <= my0;
      ex1 <= mx1;
      ey1 <= my1;
    end

    if (rst) begin
      line_kind   <= KIND_VERT;
      cursor_x    <= '0;
      cursor_y    <= '0;
      limit_coord <= '0;
      slope_q8    <= '0;
    end else if (state == S_SETUP) begin
      rem    <= '0;
      den    <= dx[MAG_BITS-1:0];
      quo    <= {dy_abs[MAG_BITS-1:0], {FRAC_BITS{1'b0}}};
      dy_neg <= dy[COORD_BITS];
      if (vertical) begin
        line_kind   <= KIND_VERT;
        cursor_x    <= ex0;
        cursor_y    <= {ymin, {FRAC_BITS{1'b0}}};
        limit_coord <= ymax;
        slope_q8    <= SLOPE_ONE;
      end else begin
        line_kind   <= horizontal ? KIND_HORZ : KIND_GEN;
        cursor_x    <= lx0;
        cursor_y    <= {ly0, {FRAC_BITS{1'b0}}};
        limit_coord <= lx1;
        slope_q8    <= '0;
      end
    end else if (state == S_DIV) begin
      rem <= take ? trial[MAG_BITS-1:0] : {rem[MAG_BITS-2:0], quo[NUM_BITS-1]};
      quo <= quo_ext[NUM_BITS-1:0];
      if (count == '0) begin
        slope_q8 <= dy_neg ? -$signed(quo_ext) : $signed(quo_ext);
      end
    end else if (push && !is_last) begin
      if (line_kind != KIND_VERT) begin
        cursor_x <= cursor_x + COORD_BITS'(1);
      end
      cursor_y <= y_sum[Y_BITS-1:0];
    end

    if (!out_valid || pop) begin
      out_pt  <= skid_valid ? skid_pt : cur_pt;
      skid_pt <= cur_pt;
    end else if (push) begin
      skid_pt <= cur_pt;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a point while the output register is empty");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready during segment setup");

  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    start_fire |=> (state == S_SETUP) && !active)
    else $error("start transaction did not enter setup");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (push && is_last) |=> !active)
    else $error("segment still active after its last point");
`endif

endmodule
